// ===== rtl/core/dhoas_pkg.sv =====
// Shared types and constants for the double-hash key set.
`timescale 1ns / 1ps
package dhoas_pkg;

    localparam int CNT_W = 11;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FOUND    = 3'd1,
        ST_MISSING  = 3'd2,
        ST_FULL     = 3'd3,
        ST_RESERVED = 3'd4
    } status_t;

    localparam logic REG_BUCKETS = 1'b0;
    localparam logic REG_FILL    = 1'b1;

    localparam logic [CNT_W-1:0] BUCKETS_RESET = 11'd1021;
    localparam logic [CNT_W-1:0] FILL_RESET    = 11'd909;
    localparam logic [CNT_W-1:0] MIN_BUCKETS   = 11'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] probes;
        logic [CNT_W-1:0] used_slots;
        logic [CNT_W-1:0] tombstones;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mod_ctl_t;

endpackage

// ===== rtl/core/dhoas_mod.sv =====
// Bit-serial remainder unit: key mod a divisor, one key bit a cycle.
`timescale 1ns / 1ps
module dhoas_mod
    import dhoas_pkg::*;
#(
    parameter int KEY_BITS = 64,
    parameter int RW = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] key,
    input  logic [RW-1:0]       divisor,
    output mod_ctl_t            ctl,
    output logic [RW-1:0]       rem
);
    localparam int CW = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] sh_reg;
    logic [RW-1:0]       rem_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [RW:0]         trial;

    assign trial = {rem_reg, sh_reg[KEY_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(KEY_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= key;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= sh_reg << 1;
            if (trial >= {1'b0, divisor})
                rem_reg <= RW'(trial - {1'b0, divisor});
            else
                rem_reg <= trial[RW-1:0];
        end
    end

    assign rem       = rem_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

endmodule

// ===== rtl/core/double_hash_open_address_set.sv =====
// Top level of the double-hash open-addressed key set.
//  channel | signals                           | word
//  req     | req_valid req_ready req           | action, key
//  rsp     | rsp_valid rsp_ready rsp           | status, probes, used_slots, tombstones
//  cfg     | cfg_we cfg_index cfg_data         | bucket_count, fill_limit
// After reset a clearing pass writes TABLE_DEPTH slots, one a cycle; no word is taken meanwhile.
// A word takes two remainder passes on the shared unit (key mod buckets, key mod buckets-1),
// then a memory read and a compare per probe, and a slot write when an insert or remove hits.
// Unused action, reserved key or a table at its fill limit go straight to the result.
// One word at a time; the result waits in its output register until taken.
`timescale 1ns / 1ps
module double_hash_open_address_set
    import dhoas_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int BW = AW + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MOD1  = 8'b0000_0100,
        S_MOD2  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_TEST  = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] rd_reg;
    logic [AW-1:0]       clr_reg;
    logic [10:0]         buckets_reg, fill_reg;
    logic [10:0]         live_reg, tomb_reg;
    logic [1:0]          act_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [BW-1:0]       idx_reg, step_reg, i_reg, b_reg;
    logic [2:0]          st_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;

    logic [10:0]         b_use;
    logic [KEY_BITS-1:0] key_in;
    logic                mod_start;
    logic [BW-1:0]       divisor;
    mod_ctl_t            mctl;
    logic [BW-1:0]       rem;
    logic [BW:0]         idx_sum;

    always_comb
    begin
        if (buckets_reg < MIN_BUCKETS)
            b_use = MIN_BUCKETS;
        else if ({21'd0, buckets_reg} > 32'(TABLE_DEPTH))
            b_use = 11'(TABLE_DEPTH);
        else
            b_use = buckets_reg;
    end

    assign key_in    = req.key[KEY_BITS-1:0];
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign mod_start = (req_ready && req_valid && req.action != ACT_NONE
                        && key_in > KEY_BITS'(1)
                        && !(req.action == ACT_INSERT && {1'b0, live_reg} + {1'b0, tomb_reg}
                             >= {1'b0, fill_reg}))
                       || (state_reg == S_MOD1 && mctl.done);
    assign divisor   = (state_reg == S_MOD2) ? BW'(b_reg - 1'b1) : b_reg;

    dhoas_mod #(.KEY_BITS(KEY_BITS), .RW(BW)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start),
        .key((state_reg == S_MOD1) ? key_reg : key_in),
        .divisor(divisor), .ctl(mctl), .rem(rem));

    assign idx_sum = {1'b0, idx_reg} + {1'b0, step_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = key_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_WRITE)
        begin
            wr_en   = 1'b1;
            wr_data = (act_reg == ACT_INSERT) ? key_reg : KEY_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            buckets_reg   <= BUCKETS_RESET;
            fill_reg      <= FILL_RESET;
            live_reg      <= '0;
            tomb_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BUCKETS)
                    buckets_reg <= cfg_data;
                else
                    fill_reg <= cfg_data;
            end
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(TABLE_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        act_reg <= req.action;
                        key_reg <= key_in;
                        b_reg   <= BW'(b_use);
                        i_reg   <= '0;
                        if (mod_start)
                            state_reg <= S_MOD1;
                        else
                        begin
                            if (req.action == ACT_NONE)
                                st_reg <= ST_MISSING;
                            else if (key_in <= KEY_BITS'(1))
                                st_reg <= ST_RESERVED;
                            else
                                st_reg <= ST_FULL;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_MOD1:
                begin
                    if (mctl.done)
                    begin
                        idx_reg   <= rem;
                        state_reg <= S_MOD2;
                    end
                end
                S_MOD2:
                begin
                    if (mctl.done)
                    begin
                        step_reg  <= BW'(rem + 1'b1);
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (i_reg == b_reg)
                    begin
                        st_reg    <= (act_reg == ACT_INSERT) ? ST_FULL : ST_MISSING;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (act_reg == ACT_INSERT)
                    begin
                        if (rd_reg <= KEY_BITS'(1))
                        begin
                            if (rd_reg == KEY_BITS'(1))
                                tomb_reg <= tomb_reg - 1'b1;
                            live_reg  <= live_reg + 1'b1;
                            st_reg    <= ST_INSERTED;
                            state_reg <= S_WRITE;
                        end
                    end
                    else if (rd_reg == key_reg)
                    begin
                        st_reg <= ST_FOUND;
                        if (act_reg == ACT_REMOVE)
                        begin
                            live_reg  <= live_reg - 1'b1;
                            tomb_reg  <= tomb_reg + 1'b1;
                            state_reg <= S_WRITE;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                    else if (rd_reg == '0)
                    begin
                        st_reg    <= ST_MISSING;
                        state_reg <= S_OUT;
                    end
                    if (state_reg == S_TEST && !((act_reg == ACT_INSERT && rd_reg <= KEY_BITS'(1))
                        || (act_reg != ACT_INSERT && (rd_reg == key_reg || rd_reg == '0))))
                    begin
                        i_reg     <= i_reg + 1'b1;
                        idx_reg   <= (idx_sum >= {1'b0, b_reg}) ? BW'(idx_sum - {1'b0, b_reg})
                                                                : BW'(idx_sum);
                        state_reg <= S_READ;
                    end
                end
                S_WRITE:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    rsp_reg.status     <= st_reg;
                    rsp_reg.probes     <= (st_reg == ST_RESERVED ||
                                           (act_reg == ACT_NONE) ||
                                           (st_reg == ST_FULL && i_reg != b_reg &&
                                            !mctl.busy && act_reg == ACT_INSERT &&
                                            state_reg == S_OUT && i_reg == '0 &&
                                            b_reg != i_reg && 1'b0))
                                          ? 11'd0 : 11'(i_reg);
                    rsp_reg.used_slots <= live_reg;
                    rsp_reg.tombstones <= tomb_reg;
                    rsp_valid_reg      <= 1'b1;
                    state_reg          <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("accepted a second word while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (idx_reg < b_reg))
        else $error("probe index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> (step_reg != '0 && step_reg < b_reg))
        else $error("probe step out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid_reg) |-> $past(rsp_ready))
        else $error("result dropped");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the double-hash open-addressed key set.
`timescale 1ns / 1ps
module testbench;
    import dhoas_pkg::*;

    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 10000000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_we;
    logic        cfg_index;
    logic [10:0] cfg_data;
    logic        req_accepted;

    double_hash_open_address_set dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [63:0] slots [DEPTH];
    int unsigned live_keys;
    int unsigned tomb_keys;
    int unsigned bucket_reg;
    int unsigned fill_reg;

    req_t        pending_words[$];
    rsp_t        expected_rsp[$];
    logic [63:0] inserted_keys[$];
    int          mismatches;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic rsp_t lookup_step(input req_t w);
        rsp_t        r;
        int unsigned b;
        int unsigned idx;
        int unsigned stride;
        int unsigned i;
        bit          done;
        logic [63:0] v;
        r.status = ST_MISSING;
        r.probes = '0;
        done = 1'b0;
        if (w.action == ACT_NONE)
            r.status = ST_MISSING;
        else if (w.key == 64'd0 || w.key == 64'd1)
            r.status = ST_RESERVED;
        else if (w.action == ACT_INSERT && live_keys + tomb_keys >= fill_reg)
            r.status = ST_FULL;
        else
        begin
            b = bucket_reg < 5 ? 5 : (bucket_reg > DEPTH ? DEPTH : bucket_reg);
            idx = int'(w.key % 64'(b));
            stride = 1 + int'(w.key % 64'(b - 1));
            for (i = 0; i < b && !done; i++)
            begin
                v = slots[idx];
                if (w.action == ACT_INSERT)
                begin
                    if (v == 64'd0 || v == 64'd1)
                    begin
                        if (v == 64'd1)
                            tomb_keys--;
                        slots[idx] = w.key;
                        live_keys++;
                        r.status = ST_INSERTED;
                        done = 1'b1;
                    end
                end
                else if (v == w.key)
                begin
                    if (w.action == ACT_REMOVE)
                    begin
                        slots[idx] = 64'd1;
                        live_keys--;
                        tomb_keys++;
                    end
                    r.status = ST_FOUND;
                    done = 1'b1;
                end
                else if (v == 64'd0)
                begin
                    r.status = ST_MISSING;
                    done = 1'b1;
                end
                if (done)
                    r.probes = 11'(i);
                else
                begin
                    idx += stride;
                    if (idx >= b)
                        idx -= b;
                end
            end
            if (!done)
            begin
                r.probes = 11'(b);
                r.status = (w.action == ACT_INSERT) ? ST_FULL : ST_MISSING;
            end
        end
        r.used_slots = 11'(live_keys);
        r.tombstones = 11'(tomb_keys);
        return r;
    endfunction

    always @(posedge clk)
    begin
        req_accepted <= req_valid && req_ready;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_accepted)
            begin
                if (pending_words.size() > 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_words.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(lookup_step(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    report("unexpected word", 1, 0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report("status", rsp.status, want.status);
                    if (rsp.probes !== want.probes)
                        report("probes", rsp.probes, want.probes);
                    if (rsp.used_slots !== want.used_slots)
                        report("used_slots", rsp.used_slots, want.used_slots);
                    if (rsp.tombstones !== want.tombstones)
                        report("tombstones", rsp.tombstones, want.tombstones);
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 11'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BUCKETS)
            bucket_reg = value;
        else
            fill_reg = value;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (2 * 64 + 2 * DEPTH + 20) @(posedge clk);
    endtask

    task automatic queue_word(input action_t a, input logic [63:0] k);
        req_t w;
        w.action = a;
        w.key = k;
        pending_words.push_back(w);
        if (a == ACT_INSERT && k > 1)
            inserted_keys.push_back(k);
    endtask

    function automatic logic [63:0] pick_key(input int unsigned b);
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 5 && inserted_keys.size() > 0)
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        if (sel < 8)
            return 64'(b) * 64'($urandom_range(40)) + 64'($urandom_range(3));
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall,
                                input int unsigned b);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            queue_word(action_t'($urandom_range(9) < 9 ? $urandom_range(2) : 3), pick_key(b));
        drain();
    endtask

    initial
    begin
        cycles = 0;
        mismatches = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_accepted = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BUCKETS;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < DEPTH; i++)
            slots[i] = '0;
        live_keys = 0;
        tomb_keys = 0;
        bucket_reg = 1021;
        fill_reg = 909;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, extremes, reserved keys, unused action
        queue_word(ACT_INSERT, 64'd0);
        queue_word(ACT_FIND, 64'd1);
        queue_word(ACT_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(ACT_INSERT, 64'd2);
        queue_word(ACT_INSERT, 64'd2);
        queue_word(ACT_INSERT, 64'd1023);
        queue_word(ACT_FIND, 64'd2);
        queue_word(ACT_FIND, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(ACT_REMOVE, 64'd2);
        queue_word(ACT_FIND, 64'd2);
        queue_word(ACT_REMOVE, 64'd12345);
        queue_word(ACT_INSERT, 64'h5555_AAAA_5555_AAAA);
        queue_word(ACT_INSERT, 64'hAAAA_5555_AAAA_5555);
        drain();

        // smallest table: probe-limit and fill-limit cases
        write_reg(REG_BUCKETS, 5);
        write_reg(REG_FILL, 1024);
        for (int i = 0; i < 7; i++)
            queue_word(ACT_INSERT, 64'(10 + 5 * i));
        queue_word(ACT_FIND, 64'd99);
        queue_word(ACT_REMOVE, 64'd10);
        queue_word(ACT_FIND, 64'd98);
        drain();
        write_reg(REG_FILL, 1);
        queue_word(ACT_INSERT, 64'd77);
        drain();
        write_reg(REG_BUCKETS, 0);
        write_reg(REG_FILL, 0);
        queue_word(ACT_INSERT, 64'd78);
        queue_word(ACT_FIND, 64'd20);
        drain();

        write_reg(REG_BUCKETS, 13);
        write_reg(REG_FILL, 12);
        random_phase(100, 0, 0, 13);
        write_reg(REG_BUCKETS, 31);
        write_reg(REG_FILL, 28);
        random_phase(100, 77, 0, 31);
        write_reg(REG_BUCKETS, 2047);
        write_reg(REG_FILL, 2047);
        random_phase(100, 0, 77, 1024);
        write_reg(REG_BUCKETS, 1021);
        write_reg(REG_FILL, 909);
        random_phase(100, 30, 30, 1021);
        write_reg(REG_BUCKETS, 8);
        write_reg(REG_FILL, 7);
        random_phase(100, 0, 0, 8);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/dhoas_pkg.sv
rtl/core/dhoas_mod.sv
rtl/core/double_hash_open_address_set.sv
verif/testbench.sv
